/* design/tasmc_pkg.sv */
// ----------------------------------------------------------------------------
// tasmc_pkg
// Shared types, codes and reset values for the two-axis stepper move
// controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tasmc_pkg;

    // field widths
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned STEPS_W = 16;
    localparam int unsigned REM_W   = 15;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_IDX_W = 1;

    // configuration reset values
    localparam logic [CFG_W-1:0] PWM_PERIOD_RST = 16'd1000;
    localparam logic [CFG_W-1:0] DUTY_LEVEL_RST = 16'd500;

    // request kinds
    typedef enum logic {
        REQ_CMD  = 1'b0,
        REQ_TICK = 1'b1
    } t_req;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PWM_PERIOD = 1'b0,
        CFG_DUTY_LEVEL = 1'b1
    } t_cfg_idx;

    // magnitude of a signed count, saturated to the remaining-count range
    function automatic logic [REM_W-1:0] mag_sat(input logic signed [STEPS_W-1:0] s);
        logic [STEPS_W-1:0] neg;
        neg = STEPS_W'(0) - STEPS_W'(s);
        if (!s[STEPS_W-1]) begin
            mag_sat = s[REM_W-1:0];
        end else if (neg[STEPS_W-1]) begin
            mag_sat = {REM_W{1'b1}};
        end else begin
            mag_sat = neg[REM_W-1:0];
        end
    endfunction

    // remaining count signed by direction
    function automatic logic [STEPS_W-1:0] signed_left(input logic [REM_W-1:0] rem,
                                                        input logic positive);
        logic [STEPS_W-1:0] ext;
        ext = {1'b0, rem};
        signed_left = positive ? ext : (STEPS_W'(0) - ext);
    endfunction

endpackage

`default_nettype wire

/* design/two_axis_stepper_move_controller.sv */
// ----------------------------------------------------------------------------
// two_axis_stepper_move_controller
// Takes move commands and timer ticks, drives x/y step and direction pins
// from a shared pwm counter and stops an axis when its limit switch trips.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ------------------------------
//  in        input      i_in_valid / o_in_stall    req_type, steps_x/y, limits
//  out       output     o_out_valid / i_out_stall  step, dir, busy, done, ok, extra
//  cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
//  one item per clock unless stalled; result shown the cycle after it is accepted
//  all work sits between the move state and one result register
//  the input stalls only while a result is held and the output side stalls
//  synchronous active-low reset clears the move state and loads the default
//  pwm period and duty level
// ----------------------------------------------------------------------------
`default_nettype none

module two_axis_stepper_move_controller (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    // configuration
    input  wire logic                                     i_cfg_we,
    input  wire logic [tasmc_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [tasmc_pkg::CFG_W-1:0]              i_cfg_data,
    // input channel
    input  wire logic                                     i_in_valid,
    output logic                                          o_in_stall,
    input  wire logic                                     i_req_type,
    input  wire logic signed [tasmc_pkg::STEPS_W-1:0]     i_steps_x,
    input  wire logic signed [tasmc_pkg::STEPS_W-1:0]     i_steps_y,
    input  wire logic                                     i_limit_neg_x,
    input  wire logic                                     i_limit_pos_x,
    input  wire logic                                     i_limit_neg_y,
    input  wire logic                                     i_limit_pos_y,
    // output channel
    output logic                                          o_out_valid,
    input  wire logic                                     i_out_stall,
    output logic                                          o_step_x,
    output logic                                          o_step_y,
    output logic                                          o_dir_x,
    output logic                                          o_dir_y,
    output logic                                          o_busy_res,
    output logic                                          o_done_res,
    output logic                                          o_move_ok,
    output logic signed [tasmc_pkg::STEPS_W-1:0]          o_extra_x,
    output logic signed [tasmc_pkg::STEPS_W-1:0]          o_extra_y
);

    localparam int unsigned CW = tasmc_pkg::CNT_W;
    localparam int unsigned SW = tasmc_pkg::STEPS_W;
    localparam int unsigned RW = tasmc_pkg::REM_W;

    // configuration registers
    logic [tasmc_pkg::CFG_W-1:0] r_period;
    logic [tasmc_pkg::CFG_W-1:0] r_duty;

    // move state
    logic [CW-1:0] r_count,  n_count;
    logic [RW-1:0] r_rem_x,  n_rem_x;
    logic [RW-1:0] r_rem_y,  n_rem_y;
    logic [1:0]    r_active, n_active;
    logic [1:0]    r_dir,    n_dir;
    logic [1:0]    r_hit,    n_hit;
    logic          r_moving, n_moving;
    logic [SW-1:0] r_left_x, n_left_x;
    logic [SW-1:0] r_left_y, n_left_y;

    // result register
    logic          r_out_valid;
    logic [1:0]    r_step,   n_step;
    logic          r_done,   n_done;
    logic          r_ok,     n_ok;

    // decode helpers
    logic          in_fire;
    logic          sx_neg, sy_neg, sx_nz, sy_nz;
    logic          px, py;
    logic          wrap;
    logic [1:0]    cmd_hit;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_fire    = i_in_valid & ~o_in_stall;

    assign sx_neg = i_steps_x[SW-1];
    assign sy_neg = i_steps_y[SW-1];
    assign sx_nz  = (i_steps_x != '0);
    assign sy_nz  = (i_steps_y != '0);
    assign px     = r_dir[0];
    assign py     = r_dir[1];

    // limit check of a new command against its own directions
    assign cmd_hit[0] = (i_limit_neg_x & sx_neg) | (i_limit_pos_x & sx_nz & ~sx_neg);
    assign cmd_hit[1] = (i_limit_neg_y & sy_neg) | (i_limit_pos_y & sy_nz & ~sy_neg);

    // next state and result for the accepted item
    always_comb begin
        n_count  = r_count;
        n_rem_x  = r_rem_x;
        n_rem_y  = r_rem_y;
        n_active = r_active;
        n_dir    = r_dir;
        n_hit    = r_hit;
        n_moving = r_moving;
        n_left_x = r_left_x;
        n_left_y = r_left_y;
        n_step   = 2'b00;
        n_done   = 1'b0;
        n_ok     = 1'b0;
        wrap     = 1'b0;

        if (tasmc_pkg::t_req'(i_req_type) == tasmc_pkg::REQ_CMD) begin
            // start a move unless one is running
            if (!r_moving) begin
                if (!sx_nz && !sy_nz) begin
                    n_done = 1'b1;
                    n_ok   = 1'b1;
                end else begin
                    n_left_x = cmd_hit[0] ? i_steps_x : '0;
                    n_left_y = cmd_hit[1] ? i_steps_y : '0;
                    if (cmd_hit == 2'b11) begin
                        n_done   = 1'b1;
                        n_active = 2'b00;
                    end else begin
                        n_active = {sy_nz, sx_nz};
                        n_dir    = {~sy_neg, ~sx_neg};
                        n_hit    = cmd_hit;
                        n_rem_x  = tasmc_pkg::mag_sat(i_steps_x);
                        n_rem_y  = tasmc_pkg::mag_sat(i_steps_y);
                        n_moving = 1'b1;
                    end
                end
            end
        end else if (r_moving) begin
            // pwm counter and step levels
            if (r_count < r_period) begin
                n_count = r_count + CW'(1);
            end else begin
                n_count = '0;
                wrap    = 1'b1;
            end
            if (r_duty > n_count) begin
                n_step = r_active;
            end

            // period end: recheck limits and count down
            if (wrap) begin
                if ((i_limit_neg_x & ~px) | (i_limit_pos_x & px)) begin
                    n_hit[0] = 1'b1;
                    n_left_x = tasmc_pkg::signed_left(r_rem_x, px);
                end
                if ((i_limit_neg_y & ~py) | (i_limit_pos_y & py)) begin
                    n_hit[1] = 1'b1;
                    n_left_y = tasmc_pkg::signed_left(r_rem_y, py);
                end
                if (n_hit[0]) begin
                    n_rem_x = '0;
                    if (r_rem_y == '0) begin
                        n_done = 1'b1;
                    end
                end
                if (!n_done && n_hit[1]) begin
                    n_rem_y = '0;
                    if (n_rem_x == '0) begin
                        n_done = 1'b1;
                    end
                end
                if (!n_done) begin
                    if (n_rem_x != '0) begin
                        n_rem_x = n_rem_x - RW'(1);
                    end else begin
                        n_active[0] = 1'b0;
                    end
                    if (n_rem_y != '0) begin
                        n_rem_y = n_rem_y - RW'(1);
                    end else begin
                        n_active[1] = 1'b0;
                    end
                    if (n_active == 2'b00) begin
                        n_done = 1'b1;
                        n_ok   = 1'b1;
                    end
                end
                if (n_done) begin
                    n_moving = 1'b0;
                    n_active = 2'b00;
                    n_step   = 2'b00;
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= tasmc_pkg::PWM_PERIOD_RST;
            r_duty   <= tasmc_pkg::DUTY_LEVEL_RST;
        end else if (i_cfg_we) begin
            unique case (tasmc_pkg::t_cfg_idx'(i_cfg_idx))
                tasmc_pkg::CFG_PWM_PERIOD: r_period <= i_cfg_data;
                tasmc_pkg::CFG_DUTY_LEVEL: r_duty   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // move state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rem_x  <= '0;
            r_rem_y  <= '0;
            r_active <= 2'b00;
            r_dir    <= 2'b00;
            r_hit    <= 2'b00;
            r_moving <= 1'b0;
            r_left_x <= '0;
            r_left_y <= '0;
        end else if (in_fire) begin
            r_count  <= n_count;
            r_rem_x  <= n_rem_x;
            r_rem_y  <= n_rem_y;
            r_active <= n_active;
            r_dir    <= n_dir;
            r_hit    <= n_hit;
            r_moving <= n_moving;
            r_left_x <= n_left_x;
            r_left_y <= n_left_y;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_step <= n_step;
            r_done <= n_done;
            r_ok   <= n_ok;
        end
    end

    // pins and leftovers follow the state, which only moves with the result
    assign o_out_valid = r_out_valid;
    assign o_step_x    = r_step[0];
    assign o_step_y    = r_step[1];
    assign o_dir_x     = r_dir[0];
    assign o_dir_y     = r_dir[1];
    assign o_busy_res  = r_moving;
    assign o_done_res  = r_done;
    assign o_move_ok   = r_ok;
    assign o_extra_x   = r_left_x;
    assign o_extra_y   = r_left_y;

    // a move is running exactly while some axis is active
    a_active_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_moving == (r_active != 2'b00))
        else $error("active axes disagree with moving flag");

    // a finished move leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> !r_moving)
        else $error("done reported while still moving");

    // success is only ever reported together with done
    a_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ok) |-> r_done)
        else $error("move_ok without done");

    // step pulses only come out of a running move
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_step != 2'b00)) |-> r_moving)
        else $error("step pulse while idle");

    // a tick that is not a period end leaves the remaining counts alone
    a_rem_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_moving && !wrap && i_req_type) |=> ($stable(r_rem_x) && $stable(r_rem_y)))
        else $error("remaining count changed off a period end");

endmodule

`default_nettype wire
